// ===== hdl/stsu_pkg.sv =====
package stsu_pkg;

	localparam int MaxTermsDefault = 64;
	localparam int DivSteps = 26;
	localparam logic [31:0] StopRatioReset = 32'h322B_CC77;
	localparam logic [31:0] DefaultNan = 32'hFFC0_0000;
	localparam logic [31:0] PosInf = 32'h7F80_0000;
	localparam logic [31:0] QuietBit = 32'h0040_0000;

	typedef enum logic [2:0] {
		OP_MUL_TX,
		OP_MUL_AX,
		OP_DIV_K,
		OP_ADD,
		OP_RATIO
	} op_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_RATIO_GO,
		ST_RATIO_WAIT,
		ST_MUL1_GO,
		ST_MUL1_WAIT,
		ST_MUL2_GO,
		ST_MUL2_WAIT,
		ST_DIV_GO,
		ST_DIV_WAIT,
		ST_ADD_GO,
		ST_ADD_WAIT,
		ST_OUT
	} state_t;

	typedef struct packed {
		logic load;
		logic start;
		op_t  op;
		logic out_load;
		logic cap;
	} dp_cmd_t;

	typedef struct packed {
		logic done;
		logic exceed;
		logic at_cap;
	} dp_sts_t;

	function automatic logic is_nan(input logic [31:0] v);
		return v[30:0] > PosInf[30:0];
	endfunction

	function automatic logic is_inf(input logic [31:0] v);
		return v[30:0] == PosInf[30:0];
	endfunction

	function automatic logic is_zero(input logic [31:0] v);
		return v[30:0] == 31'd0;
	endfunction

	function automatic logic [31:0] quiet(input logic [31:0] v);
		return v | QuietBit;
	endfunction

	function automatic logic [23:0] mant(input logic [31:0] v);
		return {v[30:23] != 8'd0, v[22:0]};
	endfunction

	function automatic logic [7:0] eff_exp(input logic [31:0] v);
		return (v[30:23] == 8'd0) ? 8'd1 : v[30:23];
	endfunction

	function automatic logic [5:0] lzc50(input logic [49:0] v);
		logic [5:0] n;
		logic found;
		n = 6'd50;
		found = 1'b0;
		for (int i = 49; i >= 0; i--) begin
			if (!found && v[i]) begin
				n = 6'(49 - i);
				found = 1'b1;
			end
		end
		return n;
	endfunction

	// m normalized with its leading one at bit 49, value m/2^49 * 2^(eb-127)
	function automatic logic [31:0] round_pack(input logic s, input logic signed [11:0] eb,
			input logic [49:0] m);
		logic [49:0] mm;
		logic [49:0] mask;
		logic [11:0] sh_w;
		logic [5:0]  sh;
		logic [23:0] keep;
		logic        g;
		logic        st;
		logic        inc;
		logic [7:0]  ef;
		logic [30:0] mag;
		if (eb >= 12'sd255) begin
			return {s, PosInf[30:0]};
		end
		if (eb >= 12'sd1) begin
			mm = m;
			ef = eb[7:0];
		end else begin
			sh_w = 12'(12'sd1 - eb);
			sh = (sh_w > 12'd63) ? 6'd63 : sh_w[5:0];
			mask = (50'd1 << sh) - 50'd1;
			mm = (m >> sh) | {49'd0, |(m & mask)};
			ef = 8'd0;
		end
		keep = mm[49:26];
		g = mm[25];
		st = |mm[24:0];
		inc = g & (st | keep[0]);
		mag = {ef, keep[22:0]} + {30'd0, inc};
		return {s, mag};
	endfunction

	function automatic logic fgt(input logic [31:0] a, input logic [31:0] b);
		logic [31:0] ka;
		logic [31:0] kb;
		ka = a[31] ? ~a : {1'b1, a[30:0]};
		kb = b[31] ? ~b : {1'b1, b[30:0]};
		if (is_nan(a) || is_nan(b)) begin
			return 1'b0;
		end
		if (is_zero(a) && is_zero(b)) begin
			return 1'b0;
		end
		return ka > kb;
	endfunction

	function automatic logic [31:0] k_to_float(input logic [13:0] k);
		logic [49:0] w;
		logic [5:0]  lz;
		w = {k, 36'd0};
		lz = lzc50(w);
		return round_pack(1'b0, 12'sd140 - $signed({6'd0, lz}), w << lz);
	endfunction

endpackage

// ===== hdl/stsu_fdiv.sv =====
module stsu_fdiv (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [31:0] a,
	input  logic [31:0] b,
	output logic        done,
	output logic [31:0] res
);

	logic               busy_q;
	logic               fin_q;
	logic               done_q;
	logic [4:0]         cnt_q;
	logic [24:0]        rem_q;
	logic [23:0]        nb_q;
	logic [25:0]        quo_q;
	logic               sgn_q;
	logic signed [11:0] ed_q;
	logic [31:0]        res_q;

	logic               sgn;
	logic               spec;
	logic [31:0]        spec_val;
	logic [5:0]         lza;
	logic [5:0]         lzb;
	logic [23:0]        na;
	logic [23:0]        nb;
	logic signed [11:0] ed;
	logic               ge;
	logic [24:0]        diff;
	logic [49:0]        w;
	logic               lz1;
	logic signed [11:0] eb;

	always_comb begin
		sgn = a[31] ^ b[31];
		spec = 1'b1;
		spec_val = stsu_pkg::DefaultNan;
		if (stsu_pkg::is_nan(a)) begin
			spec_val = stsu_pkg::quiet(a);
		end else if (stsu_pkg::is_nan(b)) begin
			spec_val = stsu_pkg::quiet(b);
		end else if ((stsu_pkg::is_inf(a) && stsu_pkg::is_inf(b)) ||
				(stsu_pkg::is_zero(a) && stsu_pkg::is_zero(b))) begin
			spec_val = stsu_pkg::DefaultNan;
		end else if (stsu_pkg::is_inf(a) || stsu_pkg::is_zero(b)) begin
			spec_val = {sgn, stsu_pkg::PosInf[30:0]};
		end else if (stsu_pkg::is_zero(a) || stsu_pkg::is_inf(b)) begin
			spec_val = {sgn, 31'd0};
		end else begin
			spec = 1'b0;
		end
		lza = stsu_pkg::lzc50({stsu_pkg::mant(a), 26'd0});
		lzb = stsu_pkg::lzc50({stsu_pkg::mant(b), 26'd0});
		na = 24'(stsu_pkg::mant(a) << lza);
		nb = 24'(stsu_pkg::mant(b) << lzb);
		ed = $signed({4'd0, stsu_pkg::eff_exp(a)}) - $signed({6'd0, lza})
			- $signed({4'd0, stsu_pkg::eff_exp(b)}) + $signed({6'd0, lzb});
		ge = rem_q >= {1'b0, nb_q};
		diff = ge ? (rem_q - {1'b0, nb_q}) : rem_q;
		lz1 = ~quo_q[25];
		w = {quo_q, 23'd0, rem_q != 25'd0};
		if (lz1) begin
			w = w << 1;
		end
		eb = ed_q + 12'sd127 - (lz1 ? 12'sd1 : 12'sd0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			fin_q  <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				if (spec) begin
					done_q <= 1'b1;
				end else begin
					busy_q <= 1'b1;
				end
			end else if (busy_q) begin
				if (cnt_q == 5'(stsu_pkg::DivSteps - 1)) begin
					busy_q <= 1'b0;
					fin_q  <= 1'b1;
				end
			end else if (fin_q) begin
				fin_q  <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			res_q <= spec_val;
			rem_q <= {1'b0, na};
			nb_q  <= nb;
			quo_q <= 26'd0;
			cnt_q <= 5'd0;
			sgn_q <= sgn;
			ed_q  <= ed;
		end else if (busy_q) begin
			rem_q <= {diff[23:0], 1'b0};
			quo_q <= {quo_q[24:0], ge};
			cnt_q <= cnt_q + 5'd1;
		end else if (fin_q) begin
			res_q <= stsu_pkg::round_pack(sgn_q, eb, w);
		end
	end

	assign done = done_q;
	assign res  = res_q;

endmodule

// ===== hdl/stsu_datapath.sv =====
module stsu_datapath #(
	parameter int MAX_TERMS = stsu_pkg::MaxTermsDefault
) (
	input  logic              clk,
	input  logic              arst_n,
	input  stsu_pkg::dp_cmd_t cmd,
	output stsu_pkg::dp_sts_t sts,
	input  logic [31:0]       x_bits,
	input  logic              stop_ratio_we,
	input  logic [31:0]       stop_ratio_wdata,
	output logic [31:0]       sum_bits,
	output logic [6:0]        term_count,
	output logic              cap_reached
);

	logic [31:0]   eps_q;
	logic [31:0]   x_q;
	logic [31:0]   term_q;
	logic [31:0]   sum_q;
	logic [31:0]   a_q;
	logic [31:0]   d_q;
	logic [6:0]    n_q;
	logic          exceed_q;
	logic          done_q;
	stsu_pkg::op_t op_q;
	logic [31:0]   sum_out_q;
	logic [6:0]    count_out_q;
	logic          cap_out_q;

	// multiplier stages
	logic          mul_v_s1;
	logic          mul_spec_s1;
	logic [31:0]   mul_sval_s1;
	logic          mul_sgn_s1;
	logic [8:0]    mul_exp_s1;
	logic [47:0]   mul_prod_s1;

	// adder stages
	logic          add_v_s1;
	logic          add_spec_s1;
	logic [31:0]   add_sval_s1;
	logic          add_sgn_s1;
	logic          add_zsgn_s1;
	logic [7:0]    add_exp_s1;
	logic [49:0]   add_w_s1;

	logic          is_mul;
	logic [31:0]   ma;
	logic          m_sgn;
	logic          m_spec;
	logic [31:0]   m_sval;
	logic [49:0]   m_p;
	logic [5:0]    m_lz;
	logic [31:0]   m_res;

	logic [31:0]   aa;
	logic [31:0]   ab;
	logic          a_spec;
	logic [31:0]   a_sval;
	logic [31:0]   big;
	logic [31:0]   sml;
	logic [7:0]    a_d;
	logic [5:0]    a_sh;
	logic [49:0]   wa;
	logic [49:0]   wb0;
	logic [49:0]   wb;
	logic [49:0]   a_mask;
	logic [49:0]   a_w;
	logic [5:0]    a_lz;
	logic [31:0]   a_res;

	logic          sum_zero;
	logic          div_start;
	logic [31:0]   div_a;
	logic [31:0]   div_b;
	logic          div_done;
	logic [31:0]   div_res;
	logic [13:0]   k;

	always_comb begin
		is_mul = (cmd.op == stsu_pkg::OP_MUL_TX) || (cmd.op == stsu_pkg::OP_MUL_AX);
		ma = (cmd.op == stsu_pkg::OP_MUL_TX) ? {~term_q[31], term_q[30:0]} : a_q;
		m_sgn = ma[31] ^ x_q[31];
		m_spec = 1'b1;
		m_sval = stsu_pkg::DefaultNan;
		if (stsu_pkg::is_nan(ma)) begin
			m_sval = stsu_pkg::quiet(ma);
		end else if (stsu_pkg::is_nan(x_q)) begin
			m_sval = stsu_pkg::quiet(x_q);
		end else if ((stsu_pkg::is_inf(ma) && stsu_pkg::is_zero(x_q)) ||
				(stsu_pkg::is_zero(ma) && stsu_pkg::is_inf(x_q))) begin
			m_sval = stsu_pkg::DefaultNan;
		end else if (stsu_pkg::is_inf(ma) || stsu_pkg::is_inf(x_q)) begin
			m_sval = {m_sgn, stsu_pkg::PosInf[30:0]};
		end else if (stsu_pkg::is_zero(ma) || stsu_pkg::is_zero(x_q)) begin
			m_sval = {m_sgn, 31'd0};
		end else begin
			m_spec = 1'b0;
		end
		m_p = {mul_prod_s1, 2'b00};
		m_lz = stsu_pkg::lzc50(m_p);
		m_res = mul_spec_s1 ? mul_sval_s1 : stsu_pkg::round_pack(mul_sgn_s1,
			$signed({3'd0, mul_exp_s1}) - 12'sd126 - $signed({6'd0, m_lz}), m_p << m_lz);
	end

	always_comb begin
		aa = sum_q;
		ab = term_q;
		a_spec = 1'b1;
		a_sval = stsu_pkg::DefaultNan;
		if (stsu_pkg::is_nan(aa)) begin
			a_sval = stsu_pkg::quiet(aa);
		end else if (stsu_pkg::is_nan(ab)) begin
			a_sval = stsu_pkg::quiet(ab);
		end else if (stsu_pkg::is_inf(aa) && stsu_pkg::is_inf(ab) && (aa[31] != ab[31])) begin
			a_sval = stsu_pkg::DefaultNan;
		end else if (stsu_pkg::is_inf(aa)) begin
			a_sval = aa;
		end else if (stsu_pkg::is_inf(ab)) begin
			a_sval = ab;
		end else begin
			a_spec = 1'b0;
		end
		if (aa[30:0] >= ab[30:0]) begin
			big = aa;
			sml = ab;
		end else begin
			big = ab;
			sml = aa;
		end
		a_d = stsu_pkg::eff_exp(big) - stsu_pkg::eff_exp(sml);
		a_sh = (a_d > 8'd63) ? 6'd63 : a_d[5:0];
		wa = {1'b0, stsu_pkg::mant(big), 25'd0};
		wb0 = {1'b0, stsu_pkg::mant(sml), 25'd0};
		a_mask = (50'd1 << a_sh) - 50'd1;
		wb = (wb0 >> a_sh) | {49'd0, |(wb0 & a_mask)};
		a_w = (big[31] == sml[31]) ? (wa + wb) : (wa - wb);
		a_lz = stsu_pkg::lzc50(add_w_s1);
		if (add_spec_s1) begin
			a_res = add_sval_s1;
		end else if (add_w_s1 == 50'd0) begin
			a_res = {add_zsgn_s1, 31'd0};
		end else begin
			a_res = stsu_pkg::round_pack(add_sgn_s1,
				$signed({4'd0, add_exp_s1}) + 12'sd1 - $signed({6'd0, a_lz}),
				add_w_s1 << a_lz);
		end
	end

	always_comb begin
		sum_zero = stsu_pkg::is_zero(sum_q);
		div_start = cmd.start && ((cmd.op == stsu_pkg::OP_DIV_K) ||
			((cmd.op == stsu_pkg::OP_RATIO) && !sum_zero));
		div_a = (cmd.op == stsu_pkg::OP_RATIO) ? term_q : a_q;
		div_b = (cmd.op == stsu_pkg::OP_RATIO) ? sum_q : d_q;
		k = {7'd0, n_q[5:0], 1'b0} * {7'd0, n_q[5:0], 1'b1};
	end

	stsu_fdiv u_fdiv (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.a      (div_a),
		.b      (div_b),
		.done   (div_done),
		.res    (div_res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			eps_q    <= stsu_pkg::StopRatioReset;
			done_q   <= 1'b0;
			mul_v_s1 <= 1'b0;
			add_v_s1 <= 1'b0;
		end else begin
			if (stop_ratio_we) begin
				eps_q <= stop_ratio_wdata;
			end
			done_q   <= 1'b0;
			mul_v_s1 <= cmd.start && is_mul;
			add_v_s1 <= cmd.start && (cmd.op == stsu_pkg::OP_ADD);
			if (mul_v_s1 || add_v_s1 || div_done) begin
				done_q <= 1'b1;
			end
			if (cmd.start && (cmd.op == stsu_pkg::OP_RATIO) && sum_zero) begin
				done_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		d_q <= stsu_pkg::k_to_float(k);
		if (cmd.start) begin
			op_q <= cmd.op;
		end
		if (cmd.load) begin
			x_q    <= x_bits;
			term_q <= x_bits;
			sum_q  <= x_bits;
			n_q    <= 7'd1;
		end
		if (cmd.start && is_mul) begin
			mul_spec_s1 <= m_spec;
			mul_sval_s1 <= m_sval;
			mul_sgn_s1  <= m_sgn;
			mul_exp_s1  <= {1'b0, stsu_pkg::eff_exp(ma)} + {1'b0, stsu_pkg::eff_exp(x_q)};
			mul_prod_s1 <= {24'd0, stsu_pkg::mant(ma)} * {24'd0, stsu_pkg::mant(x_q)};
		end
		if (mul_v_s1) begin
			a_q <= m_res;
		end
		if (cmd.start && (cmd.op == stsu_pkg::OP_ADD)) begin
			add_spec_s1 <= a_spec;
			add_sval_s1 <= a_sval;
			add_sgn_s1  <= big[31];
			add_zsgn_s1 <= aa[31] & ab[31];
			add_exp_s1  <= stsu_pkg::eff_exp(big);
			add_w_s1    <= a_w;
		end
		if (add_v_s1) begin
			sum_q <= a_res;
			n_q   <= n_q + 7'd1;
		end
		if (cmd.start && (cmd.op == stsu_pkg::OP_RATIO) && sum_zero) begin
			exceed_q <= !(stsu_pkg::is_zero(term_q) || stsu_pkg::is_nan(term_q)) &&
				stsu_pkg::fgt(stsu_pkg::PosInf, eps_q);
		end
		if (div_done) begin
			if (op_q == stsu_pkg::OP_RATIO) begin
				exceed_q <= stsu_pkg::fgt({1'b0, div_res[30:0]}, eps_q);
			end else begin
				term_q <= div_res;
			end
		end
		if (cmd.out_load) begin
			sum_out_q   <= sum_q;
			count_out_q <= n_q;
			cap_out_q   <= cmd.cap;
		end
	end

	always_comb begin
		sts.done   = done_q;
		sts.exceed = exceed_q;
		sts.at_cap = n_q >= 7'(MAX_TERMS);
	end

	assign sum_bits    = sum_out_q;
	assign term_count  = count_out_q;
	assign cap_reached = cap_out_q;

endmodule

// ===== hdl/stsu_ctrl.sv =====
module stsu_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	output logic              out_valid,
	input  logic              out_stall,
	input  stsu_pkg::dp_sts_t sts,
	output stsu_pkg::dp_cmd_t cmd
);

	stsu_pkg::state_t state_q;
	stsu_pkg::state_t state_d;
	logic             out_valid_q;
	logic             cap_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= stsu_pkg::ST_IDLE;
			out_valid_q <= 1'b0;
			cap_q       <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			if ((state_q == stsu_pkg::ST_RATIO_WAIT) && sts.done) begin
				cap_q <= sts.exceed;
			end
		end
	end

	always_comb begin
		state_d      = state_q;
		cmd.load     = 1'b0;
		cmd.start    = 1'b0;
		cmd.op       = stsu_pkg::OP_MUL_TX;
		cmd.out_load = 1'b0;
		cmd.cap      = cap_q;
		case (state_q)
			stsu_pkg::ST_IDLE: begin
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = stsu_pkg::ST_RATIO_GO;
				end
			end
			stsu_pkg::ST_RATIO_GO: begin
				cmd.start = 1'b1;
				cmd.op    = stsu_pkg::OP_RATIO;
				state_d   = stsu_pkg::ST_RATIO_WAIT;
			end
			stsu_pkg::ST_RATIO_WAIT: begin
				if (sts.done) begin
					if (!sts.exceed || sts.at_cap) begin
						state_d = stsu_pkg::ST_OUT;
					end else begin
						state_d = stsu_pkg::ST_MUL1_GO;
					end
				end
			end
			stsu_pkg::ST_MUL1_GO: begin
				cmd.start = 1'b1;
				cmd.op    = stsu_pkg::OP_MUL_TX;
				state_d   = stsu_pkg::ST_MUL1_WAIT;
			end
			stsu_pkg::ST_MUL1_WAIT: begin
				if (sts.done) begin
					state_d = stsu_pkg::ST_MUL2_GO;
				end
			end
			stsu_pkg::ST_MUL2_GO: begin
				cmd.start = 1'b1;
				cmd.op    = stsu_pkg::OP_MUL_AX;
				state_d   = stsu_pkg::ST_MUL2_WAIT;
			end
			stsu_pkg::ST_MUL2_WAIT: begin
				if (sts.done) begin
					state_d = stsu_pkg::ST_DIV_GO;
				end
			end
			stsu_pkg::ST_DIV_GO: begin
				cmd.start = 1'b1;
				cmd.op    = stsu_pkg::OP_DIV_K;
				state_d   = stsu_pkg::ST_DIV_WAIT;
			end
			stsu_pkg::ST_DIV_WAIT: begin
				if (sts.done) begin
					state_d = stsu_pkg::ST_ADD_GO;
				end
			end
			stsu_pkg::ST_ADD_GO: begin
				cmd.start = 1'b1;
				cmd.op    = stsu_pkg::OP_ADD;
				state_d   = stsu_pkg::ST_ADD_WAIT;
			end
			stsu_pkg::ST_ADD_WAIT: begin
				if (sts.done) begin
					state_d = stsu_pkg::ST_RATIO_GO;
				end
			end
			stsu_pkg::ST_OUT: begin
				if (!out_valid_q || !out_stall) begin
					cmd.out_load = 1'b1;
					state_d      = stsu_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = stsu_pkg::ST_IDLE;
			end
		endcase
	end

	assign in_stall  = state_q != stsu_pkg::ST_IDLE;
	assign out_valid = out_valid_q;

endmodule

// ===== hdl/sine_taylor_series_unit.sv =====
// channel     | handshake                   | payload
// ------------+-----------------------------+---------------------------------------
// input       | in_valid / in_stall         | x_bits[31:0]
// output      | out_valid / out_stall       | sum_bits[31:0], term_count[6:0], cap_reached
// stop ratio  | stop_ratio_we               | stop_ratio_wdata[31:0]
//
// one item at a time; a divide of finite nonzero operands runs 26 radix-2 steps,
// then a round step, then done; a series pass is the ratio test (a divide unless
// the sum is zero), two multiplies, the term divide and the add
// arst_n clears the sequencer, the output valid and sets stop ratio to 1e-8
// a waiting result sits in the output register while the next item is taken
module sine_taylor_series_unit #(
	parameter int MAX_TERMS = stsu_pkg::MaxTermsDefault
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [31:0] x_bits,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [31:0] sum_bits,
	output logic [6:0]  term_count,
	output logic        cap_reached,
	input  logic        stop_ratio_we,
	input  logic [31:0] stop_ratio_wdata
);

	stsu_pkg::dp_cmd_t cmd;
	stsu_pkg::dp_sts_t sts;

	stsu_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.sts       (sts),
		.cmd       (cmd)
	);

	stsu_datapath #(
		.MAX_TERMS (MAX_TERMS)
	) u_datapath (
		.clk              (clk),
		.arst_n           (arst_n),
		.cmd              (cmd),
		.sts              (sts),
		.x_bits           (x_bits),
		.stop_ratio_we    (stop_ratio_we),
		.stop_ratio_wdata (stop_ratio_wdata),
		.sum_bits         (sum_bits),
		.term_count       (term_count),
		.cap_reached      (cap_reached)
	);

`ifndef ASSERT_OFF
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (term_count != 7'd0) && (term_count <= 7'(MAX_TERMS)))
		else $error("term count out of range");

	a_cap_count: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && cap_reached |-> term_count == 7'(MAX_TERMS))
		else $error("cap flag without full term count");

	a_busy_after_transfer: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("input taken while busy");
`endif

endmodule

// ===== bench/sine_taylor_series_unit_tb.sv =====
`timescale 1ns / 100ps

module sine_taylor_series_unit_tb;

	typedef struct {
		logic [31:0] sum;
		logic [6:0]  count;
		logic        cap;
	} sine_result_t;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_stall;
	logic [31:0] x_bits;
	logic        out_valid;
	logic        out_stall;
	logic [31:0] sum_bits;
	logic [6:0]  term_count;
	logic        cap_reached;
	logic        stop_ratio_we;
	logic [31:0] stop_ratio_wdata;

	sine_result_t sine_queue[$];
	logic [31:0]  cur_ratio;
	int           fail_count;
	int           quiet_cycles;
	int           hold_cycles;
	int           stall_burst;
	bit           tx_idle_en;
	bit           rx_idle_en;

	sine_taylor_series_unit dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.x_bits(x_bits),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.sum_bits(sum_bits),
		.term_count(term_count),
		.cap_reached(cap_reached),
		.stop_ratio_we(stop_ratio_we),
		.stop_ratio_wdata(stop_ratio_wdata)
	);

	function automatic bit f_nan(logic [31:0] v);
		return v[30:23] == 8'hFF && v[22:0] != 23'd0;
	endfunction

	function automatic real s2r(logic [31:0] v);
		logic [63:0] d;
		logic [23:0] m;
		int e;
		e = v[30:23];
		if (v[30:0] == 31'd0) begin
			d = {v[31], 63'd0};
		end else if (e == 255) begin
			d = {v[31], 11'h7FF, v[22:0], 29'd0};
		end else begin
			if (e == 0) begin
				m = {1'b0, v[22:0]};
				e = 1;
				while (!m[23]) begin
					m = m << 1;
					e--;
				end
			end else begin
				m = {1'b1, v[22:0]};
			end
			d = {v[31], 11'(e - 127 + 1023), m[22:0], 29'd0};
		end
		return $bitstoreal(d);
	endfunction

	function automatic logic [31:0] r2s(real r);
		logic [63:0] d;
		logic [52:0] m;
		logic [52:0] keep;
		logic [30:0] mag;
		logic g;
		logic st;
		int eb;
		int sh;
		d = $realtobits(r);
		if (d[62:52] == 11'h7FF)
			return (d[51:0] != 52'd0) ? stsu_pkg::DefaultNan :
				{d[63], stsu_pkg::PosInf[30:0]};
		if (d[62:52] == 11'd0)
			return {d[63], 31'd0};
		eb = int'(d[62:52]) - 1023 + 127;
		if (eb >= 255)
			return {d[63], stsu_pkg::PosInf[30:0]};
		sh = (eb >= 1) ? 29 : 30 - eb;
		if (sh > 53)
			return {d[63], 31'd0};
		m = {1'b1, d[51:0]};
		keep = m >> sh;
		g = m[sh - 1];
		st = |(m & ((53'd1 << (sh - 1)) - 53'd1));
		mag = {(eb >= 1) ? 8'(eb) : 8'd0, keep[22:0]} + 31'(g & (st | keep[0]));
		return {d[63], mag};
	endfunction

	function automatic logic [31:0] f_mul(logic [31:0] a, logic [31:0] b);
		if (f_nan(a)) return a | stsu_pkg::QuietBit;
		if (f_nan(b)) return b | stsu_pkg::QuietBit;
		return r2s(s2r(a) * s2r(b));
	endfunction

	function automatic logic [31:0] f_div(logic [31:0] a, logic [31:0] b);
		if (f_nan(a)) return a | stsu_pkg::QuietBit;
		if (f_nan(b)) return b | stsu_pkg::QuietBit;
		return r2s(s2r(a) / s2r(b));
	endfunction

	function automatic logic [31:0] f_add(logic [31:0] a, logic [31:0] b);
		if (f_nan(a)) return a | stsu_pkg::QuietBit;
		if (f_nan(b)) return b | stsu_pkg::QuietBit;
		return r2s(s2r(a) + s2r(b));
	endfunction

	function automatic bit f_greater(logic [31:0] a, logic [31:0] b);
		if (f_nan(a) || f_nan(b)) return 0;
		return s2r(a) > s2r(b);
	endfunction

	function automatic bit term_still_large(logic [31:0] term, logic [31:0] sum,
			logic [31:0] eps);
		logic [31:0] q;
		if (sum[30:0] == 31'd0) begin
			if (term[30:0] == 31'd0 || f_nan(term)) return 0;
			return f_greater(stsu_pkg::PosInf, eps);
		end
		q = f_div(term, sum);
		return f_greater({1'b0, q[30:0]}, eps);
	endfunction

	function automatic sine_result_t sine_series(logic [31:0] x, logic [31:0] eps);
		sine_result_t res;
		logic [31:0] term;
		logic [31:0] a;
		int n;
		term = x;
		res.sum = x;
		res.count = 7'd1;
		res.cap = 1'b0;
		n = 1;
		while (term_still_large(term, res.sum, eps)) begin
			if (res.count >= 7'(stsu_pkg::MaxTermsDefault)) begin
				res.cap = 1'b1;
				break;
			end
			a = f_mul({~term[31], term[30:0]}, x);
			a = f_mul(a, x);
			term = f_div(a, r2s(real'((2 * n) * (2 * n + 1))));
			res.sum = f_add(res.sum, term);
			n++;
			res.count++;
		end
		return res;
	endfunction

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		arst_n = 1'b0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
	end

	// receiver stall
	initial begin
		out_stall = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_cycles > 0) begin
				hold_cycles--;
				out_stall <= 1'b1;
			end else if (stall_burst > 0) begin
				stall_burst--;
				out_stall <= 1'b1;
			end else if (rx_idle_en && $urandom_range(0, 5) == 0) begin
				stall_burst = $urandom_range(0, 4);
				out_stall <= 1'b1;
			end else begin
				out_stall <= 1'b0;
			end
		end
	end

	// result check
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			if (sine_queue.size() == 0) begin
				$error("unexpected result sum_bits=%h", sum_bits);
				fail_count++;
			end else begin
				sine_result_t want;
				want = sine_queue.pop_front();
				if (sum_bits !== want.sum) begin
					$error("sum_bits expected %h actual %h", want.sum, sum_bits);
					fail_count++;
				end
				if (term_count !== want.count) begin
					$error("term_count expected %0d actual %0d", want.count, term_count);
					fail_count++;
				end
				if (cap_reached !== want.cap) begin
					$error("cap_reached expected %b actual %b", want.cap, cap_reached);
					fail_count++;
				end
			end
		end
	end

	// watchdog
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall) || !arst_n)
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= 20000) begin
			$display("Test completed with failures");
			$finish;
		end
	end

	task automatic send_x(logic [31:0] x);
		if (tx_idle_en && $urandom_range(0, 3) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 5)) @(posedge clk);
		end
		in_valid <= 1'b1;
		x_bits <= x;
		do @(posedge clk); while (in_stall);
		sine_queue.push_back(sine_series(x, cur_ratio));
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		while (sine_queue.size() > 0) @(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	task automatic write_ratio(logic [31:0] v);
		stop_ratio_we <= 1'b1;
		stop_ratio_wdata <= v;
		@(posedge clk);
		stop_ratio_we <= 1'b0;
		cur_ratio = v;
	endtask

	function automatic logic [31:0] rand_x();
		case ($urandom_range(0, 9))
			0: return $urandom;
			1: return {1'($urandom), 8'($urandom_range(0, 1) ? 8'hFF : 8'h00), 23'($urandom)};
			default: return {1'($urandom), 8'($urandom_range(100, 131)), 23'($urandom)};
		endcase
	endfunction

	task automatic test_directed();
		logic [31:0] xs[$];
		xs = '{32'h0000_0000, 32'h8000_0000, 32'h7FC0_0000, 32'h7F80_0001, 32'hFFFF_FFFF,
			32'h7F80_0000, 32'hFF80_0000, 32'h7F7F_FFFF, 32'hFF7F_FFFF, 32'h0000_0001,
			32'h807F_FFFF, 32'h3F80_0000, 32'h4049_0FDB, 32'hC049_0FDB, 32'h41A0_0000,
			32'h4200_0000, 32'h3A83_126F, 32'h4C00_0000};
		foreach (xs[i]) send_x(xs[i]);
		drain();
	endtask

	task automatic test_stop_ratio_settings();
		logic [31:0] ratios[$];
		ratios = '{32'h0000_0000, 32'hFFFF_FFFF, 32'h7F80_0000, 32'hBF80_0000,
			32'h3F80_0000, 32'h3A83_126F, 32'h8000_0000, 32'h0000_0001};
		foreach (ratios[i]) begin
			write_ratio(ratios[i]);
			repeat (12) send_x(rand_x());
			send_x(32'h0000_0000);
			send_x(32'h3F80_0000);
			drain();
		end
	endtask

	task automatic test_backpressure();
		write_ratio(32'h3F80_0000);
		hold_cycles = 3000;
		repeat (10) send_x(rand_x());
		drain();
		write_ratio(stsu_pkg::StopRatioReset);
	endtask

	task automatic test_random(int items);
		for (int i = 0; i < items; i++) begin
			if (i == items - 200) begin
				tx_idle_en = 0;
				rx_idle_en = 0;
			end
			send_x(rand_x());
		end
		drain();
	endtask

	initial begin
		in_valid = 1'b0;
		x_bits = 32'd0;
		stop_ratio_we = 1'b0;
		stop_ratio_wdata = 32'd0;
		cur_ratio = stsu_pkg::StopRatioReset;
		fail_count = 0;
		quiet_cycles = 0;
		hold_cycles = 0;
		stall_burst = 0;
		tx_idle_en = 1;
		rx_idle_en = 1;
		@(posedge arst_n);
		@(posedge clk);
		test_directed();
		test_stop_ratio_settings();
		test_backpressure();
		test_random(1400);
		if (fail_count == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule
